// File: hdl/lcc_pkg.sv
// Package: shared types, constants and lookup tables for the LED color converter.
package lcc_pkg;

    typedef enum logic [1:0]
    {
        CMD_RAW   = 2'd0,
        CMD_GAMMA = 2'd1,
        CMD_HSV   = 2'd2,
        CMD_TEMP  = 2'd3
    } cmd_t;

    localparam logic [8:0]  HUE_MAX   = 9'd359;
    localparam logic [5:0]  SECTOR    = 6'd60;
    localparam logic [7:0]  TEMP_LAST = 8'd150;
    localparam logic [7:0]  TEMP_BASE = 8'd10;

    typedef struct packed
    {
        logic [1:0]  command;
        logic [7:0]  led_index;
        logic [8:0]  hue;
        logic [7:0]  saturation;
        logic [7:0]  brightness;
        logic [7:0]  red_in;
        logic [7:0]  green_in;
        logic [7:0]  blue_in;
        logic [15:0] temperature;
        logic        temp_gamma;
    } req_t;

    typedef struct packed
    {
        logic [7:0]  led_target;
        logic [23:0] grb_word;
    } rsp_t;

    localparam logic [7:0] GAMMA_LUT [256] = '{
        8'd0,8'd0,8'd0,8'd0,8'd0,8'd0,8'd0,8'd0,8'd0,8'd0,8'd0,8'd0,8'd0,8'd0,8'd0,8'd0,
        8'd0,8'd0,8'd0,8'd0,8'd0,8'd0,8'd0,8'd0,8'd0,8'd0,8'd0,8'd0,8'd1,8'd1,8'd1,8'd1,
        8'd1,8'd1,8'd1,8'd1,8'd1,8'd1,8'd1,8'd1,8'd1,8'd2,8'd2,8'd2,8'd2,8'd2,8'd2,8'd2,
        8'd2,8'd3,8'd3,8'd3,8'd3,8'd3,8'd3,8'd3,8'd4,8'd4,8'd4,8'd4,8'd4,8'd5,8'd5,8'd5,
        8'd5,8'd6,8'd6,8'd6,8'd6,8'd7,8'd7,8'd7,8'd7,8'd8,8'd8,8'd8,8'd9,8'd9,8'd9,8'd10,
        8'd10,8'd10,8'd11,8'd11,8'd11,8'd12,8'd12,8'd13,8'd13,8'd13,8'd14,8'd14,8'd15,8'd15,
        8'd16,8'd16,
        8'd17,8'd17,8'd18,8'd18,8'd19,8'd19,8'd20,8'd20,8'd21,8'd21,8'd22,8'd22,8'd23,8'd24,
        8'd24,8'd25,
        8'd25,8'd26,8'd27,8'd27,8'd28,8'd29,8'd29,8'd30,8'd31,8'd32,8'd32,8'd33,8'd34,8'd35,
        8'd35,8'd36,
        8'd37,8'd38,8'd39,8'd39,8'd40,8'd41,8'd42,8'd43,8'd44,8'd45,8'd46,8'd47,8'd48,8'd49,
        8'd50,8'd50,
        8'd51,8'd52,8'd54,8'd55,8'd56,8'd57,8'd58,8'd59,8'd60,8'd61,8'd62,8'd63,8'd64,8'd66,
        8'd67,8'd68,
        8'd69,8'd70,8'd72,8'd73,8'd74,8'd75,8'd77,8'd78,8'd79,8'd81,8'd82,8'd83,8'd85,8'd86,
        8'd87,8'd89,
        8'd90,8'd92,8'd93,8'd95,8'd96,8'd98,8'd99,8'd101,8'd102,8'd104,8'd105,8'd107,8'd109,
        8'd110,8'd112,8'd114,
        8'd115,8'd117,8'd119,8'd120,8'd122,8'd124,8'd126,8'd127,8'd129,8'd131,8'd133,8'd135,
        8'd137,8'd138,8'd140,8'd142,
        8'd144,8'd146,8'd148,8'd150,8'd152,8'd154,8'd156,8'd158,8'd160,8'd162,8'd164,8'd167,
        8'd169,8'd171,8'd173,8'd175,
        8'd177,8'd180,8'd182,8'd184,8'd186,8'd189,8'd191,8'd193,8'd196,8'd198,8'd200,8'd203,
        8'd205,8'd208,8'd210,8'd213,
        8'd215,8'd218,8'd220,8'd223,8'd225,8'd228,8'd231,8'd233,8'd236,8'd239,8'd241,8'd244,
        8'd247,8'd249,8'd252,8'd255
    };

    localparam logic [23:0] TEMP_LUT [151] = '{
        24'hff3800,24'hff4700,24'hff5300,24'hff5d00,24'hff6500,24'hff6d00,24'hff7300,
        24'hff7900,24'hff7e00,24'hff8300,
        24'hff8912,24'hff8e21,24'hff932c,24'hff9836,24'hff9d3f,24'hffa148,24'hffa54f,
        24'hffa957,24'hffad5e,24'hffb165,
        24'hffb46b,24'hffb872,24'hffbb78,24'hffbe7e,24'hffc184,24'hffc489,24'hffc78f,
        24'hffc994,24'hffcc99,24'hffce9f,
        24'hffd1a3,24'hffd3a8,24'hffd5ad,24'hffd7b1,24'hffd9b6,24'hffdbba,24'hffddbe,
        24'hffdfc2,24'hffe1c6,24'hffe3ca,
        24'hffe4ce,24'hffe6d2,24'hffe8d5,24'hffe9d9,24'hffebdc,24'hffece0,24'hffeee3,
        24'hffefe6,24'hfff0e9,24'hfff2ec,
        24'hfff3ef,24'hfff4f2,24'hfff5f5,24'hfff6f8,24'hfff8fb,24'hfff9fd,24'hfef9ff,
        24'hfcf7ff,24'hf9f6ff,24'hf7f5ff,
        24'hf5f3ff,24'hf3f2ff,24'hf0f1ff,24'heff0ff,24'hedefff,24'hebeeff,24'he9edff,
        24'he7ecff,24'he6ebff,24'he4eaff,
        24'he3e9ff,24'he1e8ff,24'he0e7ff,24'hdee6ff,24'hdde6ff,24'hdce5ff,24'hdae4ff,
        24'hd9e3ff,24'hd8e3ff,24'hd7e2ff,
        24'hd6e1ff,24'hd4e1ff,24'hd3e0ff,24'hd2dfff,24'hd1dfff,24'hd0deff,24'hcfddff,
        24'hcfddff,24'hcedcff,24'hcddcff,
        24'hccdbff,24'hcbdbff,24'hcadaff,24'hc9daff,24'hc9d9ff,24'hc8d9ff,24'hc7d8ff,
        24'hc7d8ff,24'hc6d8ff,24'hc5d7ff,
        24'hc4d7ff,24'hc4d6ff,24'hc3d6ff,24'hc3d6ff,24'hc2d5ff,24'hc1d5ff,24'hc1d4ff,
        24'hc0d4ff,24'hc0d4ff,24'hbfd3ff,
        24'hbfd3ff,24'hbed3ff,24'hbed2ff,24'hbdd2ff,24'hbdd2ff,24'hbcd2ff,24'hbcd1ff,
        24'hbbd1ff,24'hbbd1ff,24'hbad0ff,
        24'hbad0ff,24'hb9d0ff,24'hb9d0ff,24'hb9cfff,24'hb8cfff,24'hb8cfff,24'hb7cfff,
        24'hb7ceff,24'hb7ceff,24'hb6ceff,
        24'hb6ceff,24'hb6cdff,24'hb5cdff,24'hb5cdff,24'hb5cdff,24'hb4cdff,24'hb4ccff,
        24'hb4ccff,24'hb3ccff,24'hb3ccff,
        24'hb3ccff,24'hb2cbff,24'hb2cbff,24'hb2cbff,24'hb2cbff,24'hb1cbff,24'hb1caff,
        24'hb1caff,24'hb1caff,24'hb0caff,
        24'hb0caff
    };

    // divide a product below 15360 by 60 (exact for that range)
    function automatic logic [7:0] div60(input logic [13:0] x);
        logic [29:0] p;
        begin
            p = 30'(x) * 30'd17477;
            div60 = p[27:20];
        end
    endfunction

endpackage

// File: hdl/lcc_stream_if.sv
// Interface: valid/ready channel carrying one payload.
interface lcc_stream_if #(parameter type payload_t = logic);
    logic     valid;
    logic     ready;
    payload_t payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

// File: hdl/lcc_pipe.sv
// Pipeline: four-stage color conversion datapath with stall handling.
module lcc_pipe
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    output logic          in_ready,
    input  lcc_pkg::req_t in_req,
    output logic          out_valid,
    input  logic          out_ready,
    output lcc_pkg::rsp_t out_rsp
);
    import lcc_pkg::*;

    typedef struct packed
    {
        logic [1:0] command;
        logic [7:0] led;
        logic [7:0] r;
        logic [7:0] g;
        logic [7:0] b;
        logic       tg;
        logic [8:0] hue;
        logic [7:0] v;
        logic [7:0] s;
        logic [7:0] tidx;
    } s1_t;

    typedef struct packed
    {
        logic [1:0]  command;
        logic [7:0]  led;
        logic [23:0] grb;
        logic        tg;
        logic [7:0]  v;
        logic        gray;
        logic [7:0]  base;
        logic [7:0]  span;
        logic [5:0]  frac;
        logic [2:0]  sector;
    } s2_t;

    typedef struct packed
    {
        logic [7:0]  led;
        logic [23:0] grb;
        logic        hsv;
        logic        gray;
        logic [7:0]  v;
        logic [7:0]  base;
        logic [13:0] up_p;
        logic [13:0] dn_p;
        logic [2:0]  sector;
    } s3_t;

    logic adv;
    logic v1_reg, v2_reg, v3_reg, v4_reg;
    s1_t  s1_reg, s1_next;
    s2_t  s2_reg, s2_next;
    s3_t  s3_reg, s3_next;
    rsp_t s4_reg, s4_next;

    assign adv       = out_ready || !v4_reg;
    assign in_ready  = adv;
    assign out_valid = v4_reg;
    assign out_rsp   = s4_reg;

    always_comb
    begin
        logic [32:0] kprod;
        logic [9:0]  step;
        logic [8:0]  h;
        // kelvin / 100 by reciprocal multiply, exact over 16 bits
        kprod = 33'(in_req.temperature) * 33'd83887;
        step  = kprod[32:23];
        h    = (in_req.hue > HUE_MAX) ? HUE_MAX : in_req.hue;
        s1_next.command = in_req.command;
        s1_next.led     = in_req.led_index;
        s1_next.r       = in_req.red_in;
        s1_next.g       = in_req.green_in;
        s1_next.b       = in_req.blue_in;
        s1_next.tg      = in_req.temp_gamma;
        s1_next.hue     = h;
        s1_next.v       = GAMMA_LUT[in_req.brightness];
        s1_next.s       = 8'd255 - GAMMA_LUT[8'd255 - in_req.saturation];
        if (step < 10'(TEMP_BASE))
            s1_next.tidx = 8'd0;
        else if (step - 10'(TEMP_BASE) > 10'(TEMP_LAST))
            s1_next.tidx = TEMP_LAST;
        else
            s1_next.tidx = 8'(step - 10'(TEMP_BASE));
    end

    always_comb
    begin
        logic [15:0] prod;
        logic [2:0]  sec;
        logic [8:0]  rem;
        prod = 16'(8'd255 - s1_reg.s) * 16'(s1_reg.v);
        sec  = 3'((20'(s1_reg.hue) * 20'd1093) >> 16);
        rem  = s1_reg.hue - 9'(sec) * 9'(SECTOR);
        s2_next.command = s1_reg.command;
        s2_next.led     = s1_reg.led;
        s2_next.tg      = s1_reg.tg;
        s2_next.v       = s1_reg.v;
        s2_next.gray    = (s1_reg.s == 8'd0);
        s2_next.base    = prod[15:8];
        s2_next.span    = s1_reg.v - prod[15:8];
        s2_next.frac    = rem[5:0];
        s2_next.sector  = sec;
        case (cmd_t'(s1_reg.command))
            CMD_TEMP:
                s2_next.grb = {TEMP_LUT[s1_reg.tidx][15:8], TEMP_LUT[s1_reg.tidx][23:16],
                               TEMP_LUT[s1_reg.tidx][7:0]};
            default:
                s2_next.grb = {s1_reg.g, s1_reg.r, s1_reg.b};
        endcase
    end

    always_comb
    begin
        logic gam;
        gam = (cmd_t'(s2_reg.command) == CMD_GAMMA)
              || (cmd_t'(s2_reg.command) == CMD_TEMP && s2_reg.tg);
        s3_next.led    = s2_reg.led;
        s3_next.hsv    = (cmd_t'(s2_reg.command) == CMD_HSV);
        s3_next.gray   = s2_reg.gray;
        s3_next.v      = s2_reg.v;
        s3_next.base   = s2_reg.base;
        s3_next.sector = s2_reg.sector;
        s3_next.up_p   = 14'(s2_reg.span) * 14'(s2_reg.frac);
        s3_next.dn_p   = 14'(s2_reg.span) * 14'(SECTOR - s2_reg.frac);
        if (gam)
            s3_next.grb = {GAMMA_LUT[s2_reg.grb[23:16]], GAMMA_LUT[s2_reg.grb[15:8]],
                           GAMMA_LUT[s2_reg.grb[7:0]]};
        else
            s3_next.grb = s2_reg.grb;
    end

    always_comb
    begin
        logic [7:0] up, dn, v, bs, r, g, b;
        up = div60(s3_reg.up_p) + s3_reg.base;
        dn = div60(s3_reg.dn_p) + s3_reg.base;
        v  = s3_reg.v;
        bs = s3_reg.base;
        case (s3_reg.sector)
            3'd0:    begin r = v;  g = up; b = bs; end
            3'd1:    begin r = dn; g = v;  b = bs; end
            3'd2:    begin r = bs; g = v;  b = up; end
            3'd3:    begin r = bs; g = dn; b = v;  end
            3'd4:    begin r = up; g = bs; b = v;  end
            default: begin r = v;  g = bs; b = dn; end
        endcase
        s4_next.led_target = s3_reg.led;
        if (!s3_reg.hsv)
            s4_next.grb_word = s3_reg.grb;
        else if (s3_reg.gray)
            s4_next.grb_word = {v, v, v};
        else
            s4_next.grb_word = {g, r, b};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end
        else if (adv)
        begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s1_reg <= s1_next;
            s2_reg <= s2_next;
            s3_reg <= s3_next;
            s4_reg <= s4_next;
        end
    end

endmodule

// File: hdl/led_color_converter_top.sv
// Top level: LED color converter, request in, GRB word out.
//
//  channel | dir | payload
//  req     | in  | command, led_index, hue, saturation, brightness, rgb, temperature, temp_gamma
//  rsp     | out | led_target, grb_word
//
// Four register stages; one request per cycle sustained while the output is not stalled.
// Stage depth is set by the table lookups and the hue interpolation multiply.
// Reset clears all valid bits; payload registers are not reset.
// A stalled output freezes the whole pipe; nothing is dropped or repeated.
module led_color_converter_top
(
    input logic   clk,
    input logic   rst_n,
    lcc_stream_if.sink   req,
    lcc_stream_if.source rsp
);
    import lcc_pkg::*;

    lcc_pipe u_pipe
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (req.valid),
        .in_ready  (req.ready),
        .in_req    (req.payload),
        .out_valid (rsp.valid),
        .out_ready (rsp.ready),
        .out_rsp   (rsp.payload)
    );

    a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp.valid && !rsp.ready |=> rsp.valid && $stable(rsp.payload))
        else $error("response changed under stall");

    a_ready_stall: assert property (@(posedge clk) disable iff (!rst_n)
        rsp.valid && !rsp.ready |-> !req.ready)
        else $error("request taken while output stalled");

    a_no_gap: assert property (@(posedge clk) disable iff (!rst_n)
        !req.ready |-> rsp.valid)
        else $error("pipe stalled with empty output");

endmodule
